/* hdl/sds_pkg.sv */
`timescale 1ns / 1ps
// sds_pkg: shared widths, limits, register indexes and the sideband type
// for the second-difference sensor pipeline. No dependencies.

package sds_pkg;

    localparam int GRAD_W      = 26;
    localparam int MEAN_W      = 27;
    localparam int MAG_W       = 27;              // clamped magnitude, up to 2^26
    localparam int ROOT_W      = 27;
    localparam int RAD_W       = 2 * ROOT_W;      // sum of three squares
    localparam int REM_W       = ROOT_W + 3;
    localparam int DIM_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 2;
    localparam int OUT_TDATA_W = 56;

    localparam logic [GRAD_W-1:0]        GRAD_MAX  = 26'h3FF_FFFF;
    localparam logic [MAG_W-1:0]         MAG_LIMIT = 27'h400_0000;
    localparam logic signed [MEAN_W-1:0] MEAN_MAX  = 27'sh3FF_FFFF;
    localparam logic signed [MEAN_W-1:0] MEAN_MIN  = 27'sh600_0000;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_DIMENSIONS  = 1'b0;
    localparam cfg_index_t REG_MEAN_ENABLE = 1'b1;

    // per-item control and 1d results that ride along the root pipeline
    typedef struct packed {
        logic                        is_1d;
        logic                        mean_en;
        logic [GRAD_W-1:0]           grad_1d;
        logic signed [MEAN_W-1:0]    mean_1d;
    } side_t;

endpackage

/* hdl/sds_root_pipe.sv */
`timescale 1ns / 1ps
// sds_root_pipe: two-lane pipelined integer square root, one result bit per stage.
// Depends on sds_pkg for widths and the sideband type.

module sds_root_pipe import sds_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad_a,
    input  logic [RAD_W-1:0]  rad_b,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root_a,
    output logic [ROOT_W-1:0] root_b,
    output side_t             out_side
);

    logic [REM_W-1:0]  rem_reg  [ROOT_W][2];
    logic [ROOT_W-1:0] root_reg [ROOT_W][2];
    logic [RAD_W-1:0]  x_reg    [ROOT_W][2];
    side_t             side_reg [ROOT_W];
    logic              valid_reg[ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [REM_W-1:0]  rem_prev;
            logic [ROOT_W-1:0] root_prev;
            logic [RAD_W-1:0]  x_prev;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (k == 0) begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign x_prev    = (l == 0) ? rad_a : rad_b;
            end else begin : g_rest
                assign rem_prev  = rem_reg[k-1][l];
                assign root_prev = root_reg[k-1][l];
                assign x_prev    = x_reg[k-1][l];
            end

            // bring down the next two radicand bits and try root*4+1
            always_comb begin
                rem_sh = {rem_prev[REM_W-3:0], x_prev[RAD_W-1 -: 2]};
                trial  = {1'b0, root_prev, 2'b01};
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_prev[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_prev[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][l]  <= rem_next;
                    root_reg[k][l] <= root_next;
                    x_reg[k][l]    <= {x_prev[RAD_W-3:0], 2'b00};
                end
            end
        end

        if (k == 0) begin : g_ctl_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= in_valid;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[k] <= in_side;
                end
            end
        end else begin : g_ctl_rest
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root_a    = root_reg[ROOT_W-1][0];
    assign root_b    = root_reg[ROOT_W-1][1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

/* hdl/second_derivative_sensor_top.sv */
`timescale 1ns / 1ps
// second_derivative_sensor_top: stencil second differences and sums, magnitudes
// by root-sum-square. Depends on sds_pkg and sds_root_pipe.
// Pipeline: 4 arithmetic stages, 27 root stages and an output register lie between
// the input transaction and m_tvalid. Throughput: one item per cycle, set by the
// bit-per-stage root pipeline; a stalled output freezes every stage in place.
// Reset: all valid bits clear, dimensions returns to 3 and mean_enable to 0.

module second_derivative_sensor_top import sds_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    localparam int S_TDATA_W  = ((7 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_index_t             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // stencil input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // centre_value, x_left, x_right, y_bottom, y_top, z_back, z_front (low to high)
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // grad_magnitude [25:0], local_mean [52:26], zero padding above
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int DW = SAMPLE_BITS + 2;
    localparam int XW = (DW > MAG_W) ? DW : MAG_W;

    logic [DIM_W-1:0] dim_reg;
    logic             mean_en_reg;
    logic             en;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg     <= DIM_W'(3);
            mean_en_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DIMENSIONS:  dim_reg     <= cfg_data[DIM_W-1:0];
                REG_MEAN_ENABLE: mean_en_reg <= cfg_data[0];
            endcase
        end
    end

    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage 1: per-axis second difference and smoothing sum
    logic signed [DW-1:0] s1_diff_next [3];
    logic signed [DW-1:0] s1_sum_next  [3];
    logic signed [DW-1:0] s1_diff_reg  [3];
    logic signed [DW-1:0] s1_sum_reg   [3];
    logic                 s1_valid_reg;
    logic                 s1_is1d_reg;
    logic                 s1_mean_en_reg;
    logic [DIM_W-1:0]     dims_eff;

    always_comb begin
        logic [SAMPLE_BITS-1:0] fld [7];
        logic signed [DW-1:0]   c_x;
        logic signed [DW-1:0]   lo_x;
        logic signed [DW-1:0]   hi_x;
        logic                   active;
        for (int i = 0; i < 7; i++) begin
            fld[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
        end
        dims_eff = (dim_reg == '0) ? DIM_W'(1) : dim_reg;
        c_x = $signed({{2{fld[0][SAMPLE_BITS-1]}}, fld[0]});
        for (int a = 0; a < 3; a++) begin
            lo_x   = $signed({{2{fld[2*a+1][SAMPLE_BITS-1]}}, fld[2*a+1]});
            hi_x   = $signed({{2{fld[2*a+2][SAMPLE_BITS-1]}}, fld[2*a+2]});
            active = (dims_eff > DIM_W'(a));
            // inactive axes contribute zero to every square sum
            s1_diff_next[a] = active ? (hi_x + lo_x - (c_x <<< 1)) : '0;
            s1_sum_next[a]  = active ? (hi_x + lo_x + (c_x <<< 1)) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_diff_reg    <= s1_diff_next;
            s1_sum_reg     <= s1_sum_next;
            s1_is1d_reg    <= (dims_eff == DIM_W'(1));
            s1_mean_en_reg <= mean_en_reg;
        end
    end

    // stage 2: clamped magnitudes and the saturated 1d results
    logic [MAG_W-1:0] s2_mag_d_next [3];
    logic [MAG_W-1:0] s2_mag_s_next [3];
    logic [MAG_W-1:0] s2_mag_d_reg  [3];
    logic [MAG_W-1:0] s2_mag_s_reg  [3];
    side_t            s2_side_next;
    side_t            s2_side_reg;
    logic             s2_valid_reg;

    always_comb begin
        logic signed [XW:0] ext;
        logic [XW-1:0]      abs_v;
        logic signed [XW:0] hi_lim;
        logic signed [XW:0] lo_lim;
        for (int a = 0; a < 3; a++) begin
            ext   = $signed({{(XW+1-DW){s1_diff_reg[a][DW-1]}}, s1_diff_reg[a]});
            abs_v = ext[XW] ? XW'(-ext) : ext[XW-1:0];
            s2_mag_d_next[a] = (abs_v > XW'(MAG_LIMIT)) ? MAG_LIMIT : abs_v[MAG_W-1:0];
            ext   = $signed({{(XW+1-DW){s1_sum_reg[a][DW-1]}}, s1_sum_reg[a]});
            abs_v = ext[XW] ? XW'(-ext) : ext[XW-1:0];
            s2_mag_s_next[a] = (abs_v > XW'(MAG_LIMIT)) ? MAG_LIMIT : abs_v[MAG_W-1:0];
        end
        hi_lim = $signed({{(XW+1-MEAN_W){1'b0}}, MEAN_MAX});
        lo_lim = $signed({{(XW+1-MEAN_W){1'b1}}, MEAN_MIN});
        ext    = $signed({{(XW+1-DW){s1_sum_reg[0][DW-1]}}, s1_sum_reg[0]});
        s2_side_next.is_1d   = s1_is1d_reg;
        s2_side_next.mean_en = s1_mean_en_reg;
        s2_side_next.grad_1d = (s2_mag_d_next[0] == MAG_LIMIT) ? GRAD_MAX
                                                               : s2_mag_d_next[0][GRAD_W-1:0];
        priority if (ext > hi_lim) begin
            s2_side_next.mean_1d = MEAN_MAX;
        end else if (ext < lo_lim) begin
            s2_side_next.mean_1d = MEAN_MIN;
        end else begin
            s2_side_next.mean_1d = ext[MEAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_mag_d_reg <= s2_mag_d_next;
            s2_mag_s_reg <= s2_mag_s_next;
            s2_side_reg  <= s2_side_next;
        end
    end

    // stage 3: squares
    logic [RAD_W-1:0] s3_sq_d_reg [3];
    logic [RAD_W-1:0] s3_sq_s_reg [3];
    side_t            s3_side_reg;
    logic             s3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                s3_sq_d_reg[a] <= RAD_W'(s2_mag_d_reg[a]) * RAD_W'(s2_mag_d_reg[a]);
                s3_sq_s_reg[a] <= RAD_W'(s2_mag_s_reg[a]) * RAD_W'(s2_mag_s_reg[a]);
            end
            s3_side_reg <= s2_side_reg;
        end
    end

    // stage 4: sums of squares, at most 3 * 2^52
    logic [RAD_W-1:0] s4_rad_d_reg;
    logic [RAD_W-1:0] s4_rad_s_reg;
    side_t            s4_side_reg;
    logic             s4_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_rad_d_reg <= s3_sq_d_reg[0] + s3_sq_d_reg[1] + s3_sq_d_reg[2];
            s4_rad_s_reg <= s3_sq_s_reg[0] + s3_sq_s_reg[1] + s3_sq_s_reg[2];
            s4_side_reg  <= s3_side_reg;
        end
    end

    // root stages
    logic              rt_valid;
    logic [ROOT_W-1:0] rt_root_d;
    logic [ROOT_W-1:0] rt_root_s;
    side_t             rt_side;

    sds_root_pipe u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .rad_a     (s4_rad_d_reg),
        .rad_b     (s4_rad_s_reg),
        .in_side   (s4_side_reg),
        .out_valid (rt_valid),
        .root_a    (rt_root_d),
        .root_b    (rt_root_s),
        .out_side  (rt_side)
    );

    // output register: pick 1d or root result, saturate, apply mean enable
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    always_comb begin
        logic [GRAD_W-1:0]        grad;
        logic signed [MEAN_W-1:0] mean;
        if (rt_side.is_1d) begin
            grad = rt_side.grad_1d;
            mean = rt_side.mean_1d;
        end else begin
            grad = rt_root_d[ROOT_W-1] ? GRAD_MAX : rt_root_d[GRAD_W-1:0];
            mean = rt_root_s[ROOT_W-1] ? MEAN_MAX : $signed({1'b0, rt_root_s[ROOT_W-2:0]});
        end
        if (!rt_side.mean_en) begin
            mean = '0;
        end
        m_tdata_next = {{(OUT_TDATA_W-GRAD_W-MEAN_W){1'b0}}, mean, grad};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= rt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* bench/second_derivative_sensor_top_test.sv */
`timescale 1ns / 1ps
// self-checking bench for second_derivative_sensor_top: directed stencil table, then
// random stencils under several axis / mean settings, with random idling on both sides.
// Depends on sds_pkg and the second_derivative_sensor_top rtl.

module second_derivative_sensor_top_test;
    import sds_pkg::*;

    localparam logic signed [23:0] S_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] S_MIN = 24'sh80_0000;

    // first field in the lowest bits, so centre is declared last
    typedef struct packed {
        logic signed [23:0] z_front;
        logic signed [23:0] z_back;
        logic signed [23:0] y_top;
        logic signed [23:0] y_bottom;
        logic signed [23:0] x_right;
        logic signed [23:0] x_left;
        logic signed [23:0] centre;
    } stencil_t;

    typedef struct packed {
        logic [GRAD_W-1:0]        grad;
        logic signed [MEAN_W-1:0] mean;
    } magnitudes_t;

    typedef struct packed {
        logic [1:0]  dims;
        logic        mean_en;
        logic        known;
        magnitudes_t typed;
        stencil_t    st;
    } stencil_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [167:0]           s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [1:0]   cur_dims;
    logic         cur_mean_en;
    bit           calm;
    int           mismatches;
    magnitudes_t  pending_magnitudes[$];
    stencil_row_t stencil_table[$];

    second_derivative_sensor_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > x)
            probe >>= 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned root_sum_sq(input longint a, input longint b,
                                                    input longint c, input int n);
        longint unsigned acc;
        acc = a * a + b * b;
        if (n == 3)
            acc += c * c;
        return floor_sqrt(acc);
    endfunction

    function automatic magnitudes_t predict_magnitudes(input stencil_t st);
        longint      twice_c;
        longint      dx, dy, dz, sx, sy, sz;
        longint      lin;
        int          n;
        magnitudes_t r;
        n       = (cur_dims == 2'd0) ? 1 : int'(cur_dims);
        twice_c = 2 * longint'(st.centre);
        dx = longint'(st.x_right) - twice_c + longint'(st.x_left);
        dy = longint'(st.y_top) - twice_c + longint'(st.y_bottom);
        dz = longint'(st.z_front) - twice_c + longint'(st.z_back);
        sx = longint'(st.x_right) + twice_c + longint'(st.x_left);
        sy = longint'(st.y_top) + twice_c + longint'(st.y_bottom);
        sz = longint'(st.z_front) + twice_c + longint'(st.z_back);
        if (n == 1) begin
            lin    = (dx < 0) ? -dx : dx;
            r.grad = (lin > 67108863) ? GRAD_MAX : lin[GRAD_W-1:0];
            lin    = (sx > 67108863) ? 67108863 : (sx < -33554432) ? -33554432 : sx;
        end else begin
            lin    = root_sum_sq(dx, dy, dz, n);
            r.grad = (lin > 67108863) ? GRAD_MAX : lin[GRAD_W-1:0];
            lin    = root_sum_sq(sx, sy, sz, n);
            if (lin > 67108863)
                lin = 67108863;
        end
        r.mean = cur_mean_en ? lin[MEAN_W-1:0] : '0;
        return r;
    endfunction

    function automatic int draw_idle();
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [23:0] draw_sample();
        logic [23:0] raw;
        raw = 24'($urandom);
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return {{18{raw[5]}}, raw[5:0]};
            default: return raw;
        endcase
    endfunction

    function automatic logic signed [23:0] draw_neighbour(input int mode,
                                                          input logic signed [23:0] c);
        logic [23:0] raw;
        raw = 24'($urandom);
        if (mode < 4)
            return draw_sample();
        if (mode < 8)   // smooth field: neighbour close to the centre
            return c + {{14{raw[9]}}, raw[9:0]};
        case (raw[1:0])
            2'd0:    return S_MAX;
            2'd1:    return S_MIN;
            default: return '0;
        endcase
    endfunction

    function automatic stencil_t make_stencil();
        stencil_t st;
        int       mode;
        mode       = $urandom_range(0, 9);
        st.centre  = draw_sample();
        st.x_left  = draw_neighbour(mode, st.centre);
        st.x_right = draw_neighbour(mode, st.centre);
        st.y_bottom = draw_neighbour(mode, st.centre);
        st.y_top   = draw_neighbour(mode, st.centre);
        st.z_back  = draw_neighbour(mode, st.centre);
        st.z_front = draw_neighbour(mode, st.centre);
        return st;
    endfunction

    // lower the input side and wait for every outstanding result
    task automatic drain_results();
        if (pending_magnitudes.size() != 0) begin
            s_tvalid <= 1'b0;
            while (pending_magnitudes.size() != 0)
                @(posedge aclk);
        end
    endtask

    task automatic set_config(input logic [1:0] dims, input logic mean_en);
        logic spare;
        spare = 1'($urandom_range(0, 1));
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= REG_DIMENSIONS;
        cfg_data  <= dims;
        do @(posedge aclk); while (!cfg_ready);
        cur_dims  = dims;
        cfg_index <= REG_MEAN_ENABLE;
        cfg_data  <= {spare, mean_en};   // upper bit is don't-care
        do @(posedge aclk); while (!cfg_ready);
        cur_mean_en = mean_en;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_stencil(input stencil_t st, input logic known,
                                input magnitudes_t typed);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= st;
        do @(posedge aclk); while (!s_tready);
        pending_magnitudes.push_back(known ? typed : predict_magnitudes(st));
    endtask

    task automatic add_row(input logic [1:0] dims, input logic mean_en,
                           input logic signed [23:0] c, xl, xr, yb, yt, zb, zf,
                           input logic known, input longint grad, input longint mean);
        stencil_row_t row;
        row.dims       = dims;
        row.mean_en    = mean_en;
        row.known      = known;
        row.typed.grad = grad[GRAD_W-1:0];
        row.typed.mean = mean[MEAN_W-1:0];
        row.st         = '{zf, zb, yt, yb, xr, xl, c};
        stencil_table.push_back(row);
    endtask

    // result side: random stalls drawn per transaction
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_idle();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        magnitudes_t got;
        magnitudes_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.grad = m_tdata[25:0];
            got.mean = m_tdata[52:26];
            if (pending_magnitudes.size() == 0) begin
                report("unexpected result, grad_magnitude", longint'(got.grad), -1);
            end else begin
                want = pending_magnitudes.pop_front();
                if (got.grad !== want.grad)
                    report("grad_magnitude", longint'(got.grad), longint'(want.grad));
                if (got.mean !== want.mean)
                    report("local_mean", longint'(got.mean), longint'(want.mean));
            end
        end
    end

    initial begin
        stencil_t     st;
        stencil_row_t row;
        logic [1:0]   dims;
        logic         mean_en;

        mismatches  = 0;
        cur_dims    = 2'd3;
        cur_mean_en = 1'b0;
        calm        = 1'b0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_DIMENSIONS;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;

        // dims, mean, centre, x-/x+, y-/y+, z-/z+, typed?, grad, mean
        add_row(3, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(3, 0, 0, 1, 1, 1, 1, 1, 1, 0, 0, 0);
        add_row(3, 0, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 0, 0, 0);
        add_row(3, 0, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0);
        add_row(1, 1, 0, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, 1, 16777214, 16777214);
        add_row(1, 1, S_MIN, S_MAX, S_MAX, 0, 0, 0, 0, 1, 33554430, -2);
        add_row(1, 1, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, 0, 0, 1, 33554430, -2);
        add_row(1, 1, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0, 1, 0, -33554432);
        add_row(1, 1, S_MAX, S_MAX, S_MAX, 0, 0, 0, 0, 1, 0, 33554428);
        // inactive axes carry junk that must be ignored
        add_row(1, 1, 0, 1, 2, 5, -7, S_MAX, S_MIN, 1, 3, 3);
        // zero axes behaves as one
        add_row(0, 1, 0, 1, 2, 5, -7, S_MAX, S_MIN, 1, 3, 3);
        add_row(0, 1, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, 0, 0, 1, 0, -33554432);
        add_row(2, 1, 0, 3, 0, 4, 0, S_MAX, S_MAX, 1, 5, 5);
        add_row(2, 1, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, 0, 0, 0);
        add_row(2, 0, 0, 3, 0, 4, 0, S_MIN, S_MAX, 1, 5, 0);
        add_row(3, 1, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 0, 0, 0);
        add_row(3, 1, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0);
        add_row(3, 1, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0);
        add_row(3, 1, 0, -1, -2, -3, -4, -5, -6, 0, 0, 0);
        add_row(3, 1, 0, S_MAX, S_MIN, S_MIN, S_MAX, 1, -1, 0, 0, 0);
        add_row(1, 0, 5, -3, 1, S_MAX, S_MIN, S_MAX, S_MIN, 1, 12, 0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stencil_table[i]) begin
            row = stencil_table[i];
            if (row.dims != cur_dims || row.mean_en != cur_mean_en)
                set_config(row.dims, row.mean_en);
            send_stencil(row.st, row.known, row.typed);
        end

        // random phases sweep every axis count with mean on and off
        for (int p = 0; p < 13; p++) begin
            dims    = 2'(p % 4);
            mean_en = p[0] ^ p[2];
            set_config(dims, mean_en);
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 150; k++) begin
                if (p == 6 && k == 75)
                    drain_results();
                st = make_stencil();
                send_stencil(st, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_magnitudes.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/sds_pkg.sv
hdl/sds_root_pipe.sv
hdl/second_derivative_sensor_top.sv
bench/second_derivative_sensor_top_test.sv
